// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the design files. Each use names clk and rst
// of the module that it stands in.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and width helpers for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default fraction bits of the Q2.x entries
  localparam int FRAC_BITS_DEF = 14;
  // width of one matrix entry or one quaternion component
  localparam int Q_W = 16;

  // magnitude width of one unnormalized component (enough for ONE + 3 entries)
  function automatic int mag_w(input int f);
    return ((f > Q_W) ? f : Q_W) + 2;
  endfunction

  // width of the sum of four squared magnitudes
  function automatic int norm_w(input int f);
    return 2 * mag_w(f) + 2;
  endfunction

endpackage

// ----- design/rmq_norm_lane.sv -----
// ----------------------------------------------------------------------------
// rmq_norm_lane
// One component of the normalization: floor(num * 2^(2F+2) / den) by a
// one-bit-per-stage restoring divider, then its integer square root by a
// one-bit-per-stage restoring root pipeline.
// ----------------------------------------------------------------------------
module rmq_norm_lane
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2*mag_w(FRAC_BITS)-1:0]   num,
  input  logic [norm_w(FRAC_BITS)-1:0]    den,
  output logic [FRAC_BITS+1:0]            root
);

  localparam int SW = norm_w(FRAC_BITS);
  localparam int K  = 2 * FRAC_BITS + 2;
  localparam int QW = K + 1;
  localparam int RB = FRAC_BITS + 2;
  localparam int XW = 2 * RB;
  localparam int RW = RB + 3;

  logic [SW-1:0] rem_q [0:K];
  logic [SW-1:0] den_q [0:K];
  logic [QW-1:0] quo_q [0:K];

  logic [XW-1:0] x_q    [0:RB-1];
  logic [RW-1:0] srem_q [0:RB-1];
  logic [RB-1:0] root_q [0:RB-1];

  // divider: integer bit first, then one fraction bit per stage
  for (genvar j = 0; j <= K; j++) begin : g_div
    if (j == 0) begin : g_first
      logic [SW-1:0] a;
      logic          ge;
      assign a  = SW'(num);
      assign ge = (a >= den);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[0] <= ge ? (a - den) : a;
          den_q[0] <= den;
          quo_q[0] <= QW'(ge);
        end
      end
    end else begin : g_step
      logic [SW:0] r2;
      logic [SW:0] d2;
      logic        ge;
      logic [SW:0] diff;
      assign r2   = {rem_q[j-1], 1'b0};
      assign d2   = {1'b0, den_q[j-1]};
      assign ge   = (r2 >= d2);
      assign diff = r2 - d2;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= ge ? diff[SW-1:0] : r2[SW-1:0];
          den_q[j] <= den_q[j-1];
          quo_q[j] <= {quo_q[j-1][QW-2:0], ge};
        end
      end
    end
  end

  // square root: two radicand bits in, one root bit out per stage
  for (genvar s = 0; s < RB; s++) begin : g_sqrt
    logic [XW-1:0] x_in;
    logic [RW-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;
    if (s == 0) begin : g_first
      assign x_in    = XW'(quo_q[K]);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_step
      assign x_in    = x_q[s-1];
      assign rem_in  = srem_q[s-1];
      assign root_in = root_q[s-1];
    end
    assign cur   = {rem_in[RW-3:0], x_in[XW-1-2*s -: 2]};
    assign trial = RW'({root_in, 2'b01});
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        x_q[s]    <= x_in;
        srem_q[s] <= ge ? (cur - trial) : cur;
        root_q[s] <= {root_in[RB-2:0], ge};
      end
    end
  end

  assign root = root_q[RB-1];

endmodule

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to normalized unit quaternion (Shepperd branch selection).
//
//   channel  dir  word                         handshake
//   s_axis   in   r00..r22, 9 x 16 bit         tvalid/tready
//   m_axis   out  quat x,y,z,w; tuser=degen    tvalid/tready
//
// One matrix accepted per cycle while the output is not stalled. A matrix
// passes the input, branch, square, sum and output registers plus the
// per-bit divider and square root stages of the four normalization lanes.
// The whole pipeline advances whenever the output register is empty or
// taken; a stall freezes every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w from bit 0 up
  output logic [63:0]  m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);

`include "assert_macros.svh"

  localparam int VW  = mag_w(FRAC_BITS) + 1;
  localparam int MW  = mag_w(FRAC_BITS);
  localparam int SW  = norm_w(FRAC_BITS);
  localparam int RB  = FRAC_BITS + 2;
  localparam int LAT = (2 * FRAC_BITS + 3) + RB;
  localparam int EW  = RB + 17;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;
  localparam logic [Q_W-1:0] ONE_SAT =
    (FRAC_BITS > 14) ? 16'h7FFF : Q_W'(32'd1 << FRAC_BITS);

  logic pipe_en;
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // input register
  logic                  in_vld;
  logic signed [Q_W-1:0] m [0:8];
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (pipe_en) begin
      in_vld <= s_axis_tvalid;
    end
  end
  for (genvar e = 0; e < 9; e++) begin : g_in
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        m[e] <= s_axis_tdata[Q_W*e +: Q_W];
      end
    end
  end

  // branch select and unnormalized vector
  logic signed [VW-1:0] vec_next [0:3];
  logic                 bad_rad_next;
  always_comb begin
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] tr, rad;
    e00 = VW'(m[0]); e01 = VW'(m[1]); e02 = VW'(m[2]);
    e10 = VW'(m[3]); e11 = VW'(m[4]); e12 = VW'(m[5]);
    e20 = VW'(m[6]); e21 = VW'(m[7]); e22 = VW'(m[8]);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      rad = tr + ONE;
      vec_next[0] = e21 - e12; vec_next[1] = e02 - e20;
      vec_next[2] = e10 - e01; vec_next[3] = rad;
    end else if (e00 > e11 && e00 > e22) begin
      rad = ONE + e00 - e11 - e22;
      vec_next[0] = rad;       vec_next[1] = e01 + e10;
      vec_next[2] = e02 + e20; vec_next[3] = e21 - e12;
    end else if (e11 > e22) begin
      rad = ONE + e11 - e00 - e22;
      vec_next[0] = e01 + e10; vec_next[1] = rad;
      vec_next[2] = e12 + e21; vec_next[3] = e02 - e20;
    end else begin
      rad = ONE + e22 - e00 - e11;
      vec_next[0] = e02 + e20; vec_next[1] = e12 + e21;
      vec_next[2] = rad;       vec_next[3] = e10 - e01;
    end
    bad_rad_next = (rad <= 0);
  end

  logic                 vec_vld;
  logic signed [VW-1:0] vec [0:3];
  logic                 vec_bad;
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_vld <= 1'b0;
    end else if (pipe_en) begin
      vec_vld <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      vec     <= vec_next;
      vec_bad <= bad_rad_next;
    end
  end

  // magnitudes squared
  logic              sq_vld;
  logic [2*MW-1:0]   sq  [0:3];
  logic [3:0]        sq_sgn;
  logic              sq_bad;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (pipe_en) begin
      sq_vld <= vec_vld;
    end
  end
  for (genvar c = 0; c < 4; c++) begin : g_sq
    logic [VW-1:0] absv;
    assign absv = vec[c][VW-1] ? VW'(-vec[c]) : VW'(vec[c]);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq[c]     <= absv[MW-1:0] * absv[MW-1:0];
        sq_sgn[c] <= vec[c][VW-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_bad <= vec_bad;
    end
  end

  // norm squared
  logic            nm_vld;
  logic [SW-1:0]   nm;
  logic [2*MW-1:0] nm_sq [0:3];
  logic [3:0]      nm_sgn;
  logic            nm_bad;
  logic [SW-1:0]   nm_sum;
  assign nm_sum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
  always_ff @(posedge clk) begin
    if (rst) begin
      nm_vld <= 1'b0;
    end else if (pipe_en) begin
      nm_vld <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      nm     <= nm_sum;
      nm_sq  <= sq;
      nm_sgn <= sq_sgn;
      nm_bad <= sq_bad || (nm_sum == '0);
    end
  end

  // normalization lanes
  logic [RB-1:0] root [0:3];
  for (genvar c = 0; c < 4; c++) begin : g_lane
    rmq_norm_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (pipe_en),
      .num  (nm_sq[c]),
      .den  (nm),
      .root (root[c])
    );
  end

  // side pipeline: valid, signs and degenerate flag alongside the lanes
  logic       vl_d [0:LAT-1];
  logic [3:0] sg_d [0:LAT-1];
  logic       dg_d [0:LAT-1];
  for (genvar t = 0; t < LAT; t++) begin : g_side
    if (t == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vl_d[0] <= 1'b0;
        end else if (pipe_en) begin
          vl_d[0] <= nm_vld;
        end
      end
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          sg_d[0] <= nm_sgn;
          dg_d[0] <= nm_bad;
        end
      end
    end else begin : g_step
      always_ff @(posedge clk) begin
        if (rst) begin
          vl_d[t] <= 1'b0;
        end else if (pipe_en) begin
          vl_d[t] <= vl_d[t-1];
        end
      end
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          sg_d[t] <= sg_d[t-1];
          dg_d[t] <= dg_d[t-1];
        end
      end
    end
  end

  // round half up, apply sign and saturate
  logic [Q_W-1:0] comp_next [0:3];
  for (genvar c = 0; c < 4; c++) begin : g_rnd
    logic [RB:0]   inc;
    logic [EW-1:0] mag;
    assign inc = {1'b0, root[c]} + (RB+1)'(1);
    assign mag = EW'(inc[RB:1]);
    always_comb begin
      if (!sg_d[LAT-1][c]) begin
        comp_next[c] = (mag > EW'(32767)) ? 16'h7FFF : mag[Q_W-1:0];
      end else begin
        comp_next[c] = (mag > EW'(32768)) ? 16'h8000 : Q_W'(-mag[Q_W-1:0]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_axis_tvalid <= vl_d[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (dg_d[LAT-1]) begin
        m_axis_tdata <= {ONE_SAT, 48'h0};
      end else begin
        m_axis_tdata <= {comp_next[3], comp_next[2], comp_next[1], comp_next[0]};
      end
      m_axis_tuser <= dg_d[LAT-1];
    end
  end

  `RMQ_ASSERT_IMP(a_degen_identity, m_axis_tvalid && m_axis_tuser, m_axis_tdata == {ONE_SAT, 48'h0}, "degenerate word is not the identity")
  `RMQ_ASSERT_IMP(a_unit_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != 64'h0, "normalized quaternion is all zero")
  `RMQ_ASSERT_NXT(a_stall_freeze, !pipe_en, $stable(vl_d[LAT-1]) && $stable(m_axis_tdata), "pipeline moved during a stall")

endmodule
